/* hw/rtl/lpht_pkg.sv */
// Shared types and constants of the linear probing hash table.
package lpht_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 6;
  localparam int unsigned SLOT_BITS_DEF = 8;
  localparam int unsigned ENTRY_LIMIT_DEF = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_REMOVE = 2'd1,
    K_LOOKUP = 2'd2,
    K_ABSENT = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] payload;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
  } out_word_t;

  typedef struct packed {
    kind_e            kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

/* hw/rtl/lpht_fifo.sv */
// Two-entry word queue.
module lpht_fifo #(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] buf_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rptr_q];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wptr_q] <= data_i;
  end

endmodule

/* hw/rtl/lpht_front.sv */
// Request intake: classify each word and queue it for the table engine.
module lpht_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lpht_pkg::in_word_t item_i,
  output logic               full_o,
  input  logic               init_i,
  output logic               cmd_valid_o,
  output lpht_pkg::cmd_t     cmd_o,
  input  logic               cmd_pop_i
);

  lpht_pkg::cmd_t              cmd_in;
  logic [$bits(lpht_pkg::cmd_t)-1:0] cmd_raw;
  logic                        q_full, q_empty;

  always_comb begin
    cmd_in.key     = item_i.key;
    cmd_in.payload = item_i.payload;
    unique case (lpht_pkg::op_e'(item_i.opcode))
      lpht_pkg::OP_INSERT: cmd_in.kind = lpht_pkg::K_INSERT;
      lpht_pkg::OP_REMOVE: cmd_in.kind = lpht_pkg::K_REMOVE;
      lpht_pkg::OP_LOOKUP: cmd_in.kind = lpht_pkg::K_LOOKUP;
      default:             cmd_in.kind = lpht_pkg::K_ABSENT;
    endcase
    if (item_i.key == '0) cmd_in.kind = lpht_pkg::K_ABSENT;
  end

  lpht_fifo #(
    .Width($bits(lpht_pkg::cmd_t))
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && !init_i),
    .data_i (cmd_in),
    .full_o (q_full),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_raw),
    .empty_o(q_empty)
  );

  assign cmd_o       = lpht_pkg::cmd_t'(cmd_raw);
  assign cmd_valid_o = !q_empty;
  assign full_o      = q_full || init_i;

endmodule

/* hw/rtl/lpht_back.sv */
// Table engine: slot memory, probe sequencer and remove re-placement walk.
module lpht_back #(
  parameter int unsigned SLOT_BITS   = lpht_pkg::SLOT_BITS_DEF,
  parameter int unsigned ENTRY_LIMIT = lpht_pkg::ENTRY_LIMIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  lpht_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                res_push_o,
  output lpht_pkg::out_word_t res_o,
  input  logic                res_full_i,
  output logic                init_o
);

  localparam int unsigned Slots = 1 << SLOT_BITS;
  localparam int unsigned CntW  = SLOT_BITS + 1;
  localparam int unsigned Cap   = (ENTRY_LIMIT < Slots) ? ENTRY_LIMIT : Slots;

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_PROBE    = 7'b0000100,
    S_WALK_RD  = 7'b0001000,
    S_WALK     = 7'b0010000,
    S_PLACE_RD = 7'b0100000,
    S_PLACE    = 7'b1000000
  } state_e;

  state_e                        state_q, state_d;
  logic [SLOT_BITS-1:0]          p_q, p_d, i_q, i_d, j_q, j_d;
  logic [CntW-1:0]               w_q, w_d, cnt_q, cnt_d;
  lpht_pkg::kind_e               op_q, op_d;
  logic [lpht_pkg::KEY_W-1:0]    key_q, key_d;
  logic [lpht_pkg::VAL_W-1:0]    val_q, val_d;

  lpht_pkg::entry_t              mem [Slots];
  lpht_pkg::entry_t              rdata_q, wd;
  logic                          we;
  logic [SLOT_BITS-1:0]          wa, ra;
  logic                          hit, emp, last_i;

  assign hit    = (rdata_q.key == key_q);
  assign emp    = (rdata_q.key == '0);
  assign last_i = &i_q;
  assign init_o = (state_q == S_CLEAR);

  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    i_d        = i_q;
    j_d        = j_q;
    w_d        = w_q;
    cnt_d      = cnt_q;
    op_d       = op_q;
    key_d      = key_q;
    val_d      = val_q;
    we         = 1'b0;
    wa         = p_q;
    wd         = '0;
    ra         = p_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      S_CLEAR: begin
        we  = 1'b1;
        p_d = p_q + 1'b1;
        if (&p_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == lpht_pkg::K_ABSENT) begin
            res_push_o   = 1'b1;
            res_o.status = lpht_pkg::ST_ABSENT;
          end else begin
            op_d    = cmd_i.kind;
            key_d   = cmd_i.key;
            val_d   = cmd_i.payload;
            p_d     = cmd_i.key[SLOT_BITS-1:0];
            i_d     = '0;
            ra      = cmd_i.key[SLOT_BITS-1:0];
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (hit || emp) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
          case (op_q)
            lpht_pkg::K_LOOKUP: begin
              if (hit) begin
                res_o.status      = lpht_pkg::ST_OK;
                res_o.found_value = rdata_q.value;
              end else begin
                res_o.status = lpht_pkg::ST_ABSENT;
              end
            end
            lpht_pkg::K_INSERT: begin
              if (emp && (cnt_q >= CntW'(Cap))) begin
                res_o.status = lpht_pkg::ST_FULL;
              end else begin
                res_o.status = lpht_pkg::ST_OK;
                we           = 1'b1;
                wd.key       = key_q;
                wd.value     = val_q;
                if (emp) cnt_d = cnt_q + 1'b1;
              end
            end
            lpht_pkg::K_REMOVE: begin
              if (hit) begin
                res_o.status = lpht_pkg::ST_OK;
                we           = 1'b1;
                if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
                j_d          = p_q + 1'b1;
                ra           = p_q + 1'b1;
                w_d          = '0;
                state_d      = S_WALK;
              end else begin
                res_o.status = lpht_pkg::ST_ABSENT;
              end
            end
            default: res_o.status = lpht_pkg::ST_ABSENT;
          endcase
        end else if (last_i) begin
          res_push_o   = 1'b1;
          res_o.status = (op_q == lpht_pkg::K_INSERT) ? lpht_pkg::ST_FULL
                                                      : lpht_pkg::ST_ABSENT;
          state_d      = S_IDLE;
        end else begin
          p_d = p_q + 1'b1;
          i_d = i_q + 1'b1;
          ra  = p_q + 1'b1;
        end
      end
      S_WALK_RD: begin
        ra      = j_q;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (emp || (w_q == CntW'(Slots))) begin
          state_d = S_IDLE;
        end else begin
          key_d   = rdata_q.key;
          val_d   = rdata_q.value;
          we      = 1'b1;
          wa      = j_q;
          p_d     = rdata_q.key[SLOT_BITS-1:0];
          i_d     = '0;
          state_d = S_PLACE_RD;
        end
      end
      S_PLACE_RD: begin
        ra      = p_q;
        state_d = S_PLACE;
      end
      S_PLACE: begin
        if (hit || emp || last_i) begin
          if (hit || emp) begin
            we       = 1'b1;
            wd.key   = key_q;
            wd.value = val_q;
          end
          j_d     = j_q + 1'b1;
          w_d     = w_q + 1'b1;
          state_d = S_WALK_RD;
        end else begin
          p_d = p_q + 1'b1;
          i_d = i_q + 1'b1;
          ra  = p_q + 1'b1;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      p_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      w_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      i_q     <= i_d;
      j_q     <= j_d;
      w_q     <= w_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    key_q <= key_d;
    val_q <= val_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rdata_q <= mem[ra];
  end

`ifndef SYNTH
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Cap))
    else $error("entry count above capacity");

  a_res_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_no_pop_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !cmd_pop_o)
    else $error("command taken during clearing pass");

  a_remove_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE && op_q == lpht_pkg::K_REMOVE && hit) |=> (state_q == S_WALK))
    else $error("remove hit did not start the walk");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == S_IDLE && cmd_valid_i))
    else $error("command popped outside idle");
`endif

endmodule

/* hw/rtl/linear_probe_hash_table.sv */
// Top level of the linear probing hash table.
//
//  channel   | handshake          | word
//  ----------+--------------------+-----------------------------------
//  request   | push / full        | item_i   (opcode, key, payload)
//  result    | pop / empty        | result_o (status, found_value)
//
// After reset a clearing pass writes every slot, with full high.
// A request probes slots one after another through the memory read port.
// A remove that hits then walks the following slots and re-places each entry found.
// Words with a zero key or an unused opcode are answered absent without a probe.
// Two-word queues on each side let intake and result draining stall independently.
module linear_probe_hash_table #(
  parameter int unsigned SLOT_BITS   = lpht_pkg::SLOT_BITS_DEF,
  parameter int unsigned ENTRY_LIMIT = lpht_pkg::ENTRY_LIMIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  lpht_pkg::in_word_t  item_i,
  output logic                full,
  input  logic                pop,
  output lpht_pkg::out_word_t result_o,
  output logic                empty
);

  logic                cmd_valid, cmd_pop, res_push, res_full, init;
  lpht_pkg::cmd_t      cmd;
  lpht_pkg::out_word_t res;
  logic [$bits(lpht_pkg::out_word_t)-1:0] res_raw;

  lpht_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .init_i     (init),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  lpht_back #(
    .SLOT_BITS  (SLOT_BITS),
    .ENTRY_LIMIT(ENTRY_LIMIT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_push_o (res_push),
    .res_o      (res),
    .res_full_i (res_full),
    .init_o     (init)
  );

  lpht_fifo #(
    .Width($bits(lpht_pkg::out_word_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_raw),
    .empty_o(empty)
  );

  assign result_o = lpht_pkg::out_word_t'(res_raw);

endmodule

/* dv/lpht_tb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the linear probing hash table: table predictor and result checks.
package lpht_tb_pkg;
  import lpht_pkg::*;

  localparam int unsigned NUM_SLOTS = 1 << SLOT_BITS_DEF;
  localparam int unsigned MAX_FILL  = (ENTRY_LIMIT_DEF < NUM_SLOTS) ? ENTRY_LIMIT_DEF : NUM_SLOTS;

  class hash_table_scoreboard;
    logic [KEY_W-1:0] slot_key [NUM_SLOTS];
    logic [VAL_W-1:0] slot_val [NUM_SLOTS];
    int unsigned      fill;
    out_word_t        awaited_answers[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      n_insert, n_remove, n_lookup, n_full, n_absent, n_hit;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_key[i] = '0;
        slot_val[i] = '0;
      end
      fill = 0;
      errors = 0;
      checked = 0;
      n_insert = 0;
      n_remove = 0;
      n_lookup = 0;
      n_full = 0;
      n_absent = 0;
      n_hit = 0;
    endfunction

    function int unsigned pending();
      return awaited_answers.size();
    endfunction

    function int unsigned walk(logic [KEY_W-1:0] key, output bit found_slot);
      int unsigned s;
      s = key & (NUM_SLOTS - 1);
      found_slot = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_key[s] == '0 || slot_key[s] == key) begin
          found_slot = 1'b1;
          return s;
        end
        s = (s + 1) % NUM_SLOTS;
      end
      return 0;
    endfunction

    function void rehome(logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
      int unsigned s;
      bit          ok;
      s = walk(key, ok);
      if (ok) begin
        slot_key[s] = key;
        slot_val[s] = val;
      end
    endfunction

    function out_word_t answer_request(in_word_t w);
      out_word_t   ans;
      int unsigned s;
      bit          ok;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      ans.status = ST_ABSENT;
      ans.found_value = '0;
      if (w.key != '0) begin
        case (op_e'(w.opcode))
          OP_INSERT: begin
            n_insert++;
            s = walk(w.key, ok);
            if (!ok) begin
              ans.status = ST_FULL;
            end else if (slot_key[s] == '0 && fill >= MAX_FILL) begin
              ans.status = ST_FULL;
            end else begin
              if (slot_key[s] == '0) fill++;
              slot_key[s] = w.key;
              slot_val[s] = w.payload;
              ans.status = ST_OK;
            end
          end
          OP_REMOVE: begin
            n_remove++;
            s = walk(w.key, ok);
            if (ok && slot_key[s] == w.key) begin
              slot_key[s] = '0;
              slot_val[s] = '0;
              if (fill > 0) fill--;
              s = (s + 1) % NUM_SLOTS;
              for (int i = 0; i < NUM_SLOTS && slot_key[s] != '0; i++) begin
                k = slot_key[s];
                v = slot_val[s];
                slot_key[s] = '0;
                slot_val[s] = '0;
                rehome(k, v);
                s = (s + 1) % NUM_SLOTS;
              end
              ans.status = ST_OK;
            end
          end
          OP_LOOKUP: begin
            n_lookup++;
            s = walk(w.key, ok);
            if (ok && slot_key[s] == w.key) begin
              ans.status = ST_OK;
              ans.found_value = slot_val[s];
              n_hit++;
            end
          end
          default: ;
        endcase
      end
      if (ans.status == ST_FULL) n_full++;
      if (ans.status == ST_ABSENT) n_absent++;
      return ans;
    endfunction

    function void note_request(in_word_t w);
      awaited_answers.push_back(answer_request(w));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(out_word_t got);
      out_word_t exp;
      if (awaited_answers.size() == 0) begin
        report($sformatf("result word %h with nothing awaited", got));
      end else begin
        exp = awaited_answers.pop_front();
        checked++;
        if (got.status !== exp.status)
          report($sformatf("word %0d status %0d, expected %0d", checked, got.status, exp.status));
        if (got.found_value !== exp.found_value)
          report($sformatf("word %0d found_value %0d, expected %0d", checked,
                           got.found_value, exp.found_value));
      end
    endtask
  endclass

endpackage

/* dv/tb_linear_probe_hash_table.sv */
`timescale 1ns / 100ps
// Testbench for the linear probing hash table: directed and random requests against a predictor.
module tb_linear_probe_hash_table;
  import lpht_pkg::*;
  import lpht_tb_pkg::*;

  localparam int unsigned POOL_SIZE  = 96;
  localparam int unsigned NUM_PHASES = 13;
  localparam int unsigned PHASE_LEN  = 150;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  in_word_t  item_i = '0;
  logic      full;
  logic      pop = 1'b0;
  out_word_t result_o;
  logic      empty;

  hash_table_scoreboard sb = new();
  logic [KEY_W-1:0]     key_pool [POOL_SIZE];
  bit                   no_idle = 1'b0;
  bit                   held_once = 1'b0;
  int unsigned          ins_pct [NUM_PHASES] = '{85, 85, 70, 50, 30, 15, 60, 90, 90, 40, 20,
                                                 50, 70};

  linear_probe_hash_table uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .item_i  (item_i),
    .full    (full),
    .pop     (pop),
    .result_o(result_o),
    .empty   (empty)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic send_word(in_word_t w);
    int unsigned gap;
    @(negedge clk_i);
    push <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (full);
    sb.note_request(w);
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_req(op_e op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
    in_word_t w;
    w.opcode = op;
    w.key = key;
    w.payload = val;
    send_word(w);
  endtask

  task automatic send_random(int unsigned ipct);
    in_word_t    w;
    int unsigned r;
    r = $urandom_range(0, 99);
    w.payload = VAL_W'($urandom_range(0, 63));
    w.key = pick_key();
    if (r < ipct) w.opcode = OP_INSERT;
    else if ($urandom_range(0, 9) < 6) w.opcode = OP_LOOKUP;
    else w.opcode = OP_REMOVE;
    r = $urandom_range(0, 99);
    if (r < 3) w.key = '0;
    else if (r < 5) w.opcode = OP_NONE;
    send_word(w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_once && sb.checked >= 500) begin
        held_once = 1'b1;
        stall = 400;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        sb.check_result(result_o);
        stall = idle_len();
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom();
      if ($urandom_range(0, 3) != 0) key_pool[i][7:0] = 8'hF8 + 8'($urandom_range(0, 15));
      if (key_pool[i] == '0) key_pool[i] = 32'h0000_0100;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_req(OP_LOOKUP, 32'h1234_5678, 6'd0);
    send_req(OP_INSERT, 32'h0000_0000, 6'd63);
    send_req(OP_REMOVE, 32'h0000_0000, 6'd0);
    send_req(OP_LOOKUP, 32'h0000_0000, 6'd0);
    send_req(OP_NONE,   32'hDEAD_BEEF, 6'd5);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 6'd63);
    send_req(OP_INSERT, 32'h0000_0001, 6'd0);
    send_req(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0);
    send_req(OP_LOOKUP, 32'h0000_0001, 6'd0);
    send_req(OP_INSERT, 32'hFFFF_FFFF, 6'd21);
    send_req(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0);
    send_req(OP_INSERT, 32'h1000_00FF, 6'd1);
    send_req(OP_INSERT, 32'h2000_00FF, 6'd2);
    send_req(OP_INSERT, 32'h3000_00FF, 6'd3);
    send_req(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
    send_req(OP_LOOKUP, 32'h3000_00FF, 6'd0);
    send_req(OP_LOOKUP, 32'h0000_0001, 6'd0);
    send_req(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
    send_req(OP_REMOVE, 32'h1000_00FF, 6'd0);
    send_req(OP_LOOKUP, 32'h2000_00FF, 6'd0);
    send_req(OP_NONE,   32'h0000_0000, 6'd0);
    send_req(OP_LOOKUP, 32'h0000_0001, 6'd63);

    for (int p = 0; p < NUM_PHASES; p++) begin
      no_idle = (p == 3 || p == 9);
      if (p == 6) drain();
      for (int i = 0; i < PHASE_LEN; i++) send_random(ins_pct[p]);
    end
    no_idle = 1'b0;

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results still awaited at end of run");

    $display("Covered %0d inserts, %0d removes, %0d lookups (%0d hits); %0d results checked.",
             sb.n_insert, sb.n_remove, sb.n_lookup, sb.n_hit, sb.checked);
    $display("Answers: %0d table full, %0d key absent; %0d mismatches.",
             sb.n_full, sb.n_absent, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
